@@ design/spq_pkg.sv @@
package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int PRIO_W = 8;
  localparam int PAY_W  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_QUERY = 2'd0,
    MODE_ENQ   = 2'd1,
    MODE_DEQ   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // broadcast to every cell for one beat
  typedef struct packed {
    logic              enq;
    logic              deq;
    logic [PRIO_W-1:0] prio;
    logic [PAY_W-1:0]  pay;
  } spq_cmd_t;

endpackage

@@ design/stable_priority_queue.sv @@
// done is registered: a command's result beat is shown in the cycle after the command is accepted.
// Throughput: one command per cycle; busy is never raised, since every cell does its
//   compare-and-shift combinationally into its one register.
// Reset (rst, synchronous): empties the queue and drops any pending result; slot contents
//   are left as they are. The receiver cannot stall: each result beat is shown for one cycle.
module stable_priority_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 mode,
  input  logic [spq_pkg::PAY_W-1:0]  payload,
  input  logic [spq_pkg::PRIO_W-1:0] priority_req,
  input  logic [spq_pkg::PRIO_W-1:0] query_priority,
  output logic                       done,
  output logic [1:0]                 status,
  output logic                       out_valid,
  output logic [spq_pkg::PAY_W-1:0]  out_payload,
  output logic                       head_valid,
  output logic [spq_pkg::PRIO_W-1:0] head_priority,
  output logic [spq_pkg::PAY_W-1:0]  head_payload,
  output logic                       head_match,
  output logic [spq_pkg::CNT_W-1:0]  entry_count
);
  import spq_pkg::*;

  // Row of cells, cell 0 is the head. Entries stay sorted by priority;
  // on enqueue each cell either holds, takes the new entry, or takes its
  // left neighbor's entry. On dequeue every cell but the tail takes its right neighbor.

  logic                 accept;
  logic                 full;
  logic                 empty;
  spq_cmd_t             cmd;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  status_t              status_next;

  logic [DEPTH-1:0]     occ;
  logic [DEPTH-1:0]     keep;
  logic [PRIO_W-1:0]    cell_prio      [DEPTH];
  logic [PAY_W-1:0]     cell_pay       [DEPTH];
  logic [PRIO_W-1:0]    cell_prio_next [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);

  // per-beat command; rejected enqueue/dequeue leave the cells alone
  always_comb begin
    cmd.enq     = 1'b0;
    cmd.deq     = 1'b0;
    cmd.prio    = priority_req;
    cmd.pay     = payload;
    count_next  = count;
    status_next = ST_OK;
    case (mode)
      MODE_ENQ: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.enq    = accept;
          count_next = count + CNT_W'(1);
        end
      end
      MODE_DEQ: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          cmd.deq    = accept;
          count_next = count - CNT_W'(1);
        end
      end
      MODE_CLEAR: count_next = '0;
      default:    count_next = count;
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      assign occ[gi] = (CNT_W'(gi) < count);
      if (gi == 0) begin : g_head
        spq_cell u_cell (
          .clk        (clk),
          .cmd        (cmd),
          .occ        (occ[gi]),
          .left_keep  (1'b1),
          .left_prio  (cell_prio[gi]),
          .left_pay   (cell_pay[gi]),
          .right_prio (cell_prio[gi+1]),
          .right_pay  (cell_pay[gi+1]),
          .keep       (keep[gi]),
          .prio       (cell_prio[gi]),
          .pay        (cell_pay[gi]),
          .prio_next  (cell_prio_next[gi])
        );
      end else if (gi == DEPTH - 1) begin : g_tail
        // tail takes its own value on dequeue: that slot falls out of range anyway
        spq_cell u_cell (
          .clk        (clk),
          .cmd        (cmd),
          .occ        (occ[gi]),
          .left_keep  (keep[gi-1]),
          .left_prio  (cell_prio[gi-1]),
          .left_pay   (cell_pay[gi-1]),
          .right_prio (cell_prio[gi]),
          .right_pay  (cell_pay[gi]),
          .keep       (keep[gi]),
          .prio       (cell_prio[gi]),
          .pay        (cell_pay[gi]),
          .prio_next  (cell_prio_next[gi])
        );
      end else begin : g_mid
        spq_cell u_cell (
          .clk        (clk),
          .cmd        (cmd),
          .occ        (occ[gi]),
          .left_keep  (keep[gi-1]),
          .left_prio  (cell_prio[gi-1]),
          .left_pay   (cell_pay[gi-1]),
          .right_prio (cell_prio[gi+1]),
          .right_pay  (cell_pay[gi+1]),
          .keep       (keep[gi]),
          .prio       (cell_prio[gi]),
          .pay        (cell_pay[gi]),
          .prio_next  (cell_prio_next[gi])
        );
      end
    end
  endgenerate

  // result beat registers; head fields come straight off cell 0
  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
    if (accept) begin
      status      <= status_next;
      out_valid   <= cmd.deq;
      out_payload <= cmd.deq ? cell_pay[0] : '0;
      head_match  <= (count_next != '0) && (cell_prio_next[0] == query_priority);
    end
  end

  assign entry_count   = count;
  assign head_valid    = (count != '0);
  assign head_priority = head_valid ? cell_prio[0] : '0;
  assign head_payload  = head_valid ? cell_pay[0] : '0;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");
  a_deq_ok: assert property (@(posedge clk) disable iff (rst)
    done && out_valid |-> status == ST_OK)
    else $error("dequeue beat with error status");
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> count == CNT_W'(DEPTH))
    else $error("full flagged below depth");
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> count == '0)
    else $error("empty flagged with entries held");
  a_deq_shrinks: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.deq |=> count == $past(count) - CNT_W'(1))
    else $error("dequeue did not shrink count");
`endif

endmodule

@@ design/spq_cell.sv @@
module spq_cell (
  input  logic                     clk,
  input  spq_pkg::spq_cmd_t        cmd,
  input  logic                     occ,
  input  logic                     left_keep,
  input  logic [spq_pkg::PRIO_W-1:0] left_prio,
  input  logic [spq_pkg::PAY_W-1:0]  left_pay,
  input  logic [spq_pkg::PRIO_W-1:0] right_prio,
  input  logic [spq_pkg::PAY_W-1:0]  right_pay,
  output logic                     keep,
  output logic [spq_pkg::PRIO_W-1:0] prio,
  output logic [spq_pkg::PAY_W-1:0]  pay,
  output logic [spq_pkg::PRIO_W-1:0] prio_next
);
  import spq_pkg::*;

  logic [PAY_W-1:0] pay_next;

  // occupied and at least as urgent as the new entry (priority value not above it): stays put on enqueue
  assign keep = occ && (prio <= cmd.prio);

  always_comb begin
    prio_next = prio;
    pay_next  = pay;
    if (cmd.enq && !keep) begin
      if (left_keep) begin
        prio_next = cmd.prio;
        pay_next  = cmd.pay;
      end else begin
        prio_next = left_prio;
        pay_next  = left_pay;
      end
    end else if (cmd.deq) begin
      prio_next = right_prio;
      pay_next  = right_pay;
    end
  end

  always_ff @(posedge clk) begin
    prio <= prio_next;
    pay  <= pay_next;
  end

endmodule
